// File: sv/sld_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; imported by sld_csr_if and every module.
package sld_pkg;

   localparam int LENGTH_BITS_DEF = 16;

   localparam logic [7:0] SYNC_A = 8'h11;
   localparam logic [7:0] SYNC_B = 8'h22;
   localparam logic [7:0] SYNC_C = 8'h33;

   localparam logic [7:0] CMD_SCREEN = 8'd1;
   localparam logic [7:0] CMD_CALC   = 8'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd250;
   localparam logic [15:0] PLANE_RESET   = 16'd2888;

   // input op codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // dispatch targets
   localparam logic [1:0] TGT_NONE   = 2'd0;
   localparam logic [1:0] TGT_SCREEN = 2'd1;
   localparam logic [1:0] TGT_CALC   = 2'd2;

   // register indexes
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE   = 8'd1;

   // parser phases
   localparam logic [3:0] PH_HUNT1 = 4'd0;
   localparam logic [3:0] PH_HUNT2 = 4'd1;
   localparam logic [3:0] PH_HUNT3 = 4'd2;
   localparam logic [3:0] PH_CMD   = 4'd3;
   localparam logic [3:0] PH_LENH  = 4'd4;
   localparam logic [3:0] PH_LENL  = 4'd5;
   localparam logic [3:0] PH_DATA  = 4'd6;
   localparam logic [3:0] PH_SUM   = 4'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  command;
      logic [1:0]  target;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic        plane;
      logic [15:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic [3:0] phase;
   } parser_status_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } queue_status_type;

endpackage

// File: sv/sld_if.sv
`timescale 1ns / 1ps
// Channel interfaces: request beats, result beats and register writes.
// Depends on sld_pkg.
interface sld_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface sld_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  command;
   logic [1:0]  target;
   logic [7:0]  payload_byte;
   logic [15:0] byte_index;
   logic        plane;
   logic [15:0] frame_length;
   modport source (output valid, output kind, output command, output target,
                   output payload_byte, output byte_index, output plane,
                   output frame_length, input ready);
   modport sink   (input valid, input kind, input command, input target,
                   input payload_byte, input byte_index, input plane,
                   input frame_length, output ready);
endinterface

interface sld_csr_if import sld_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [15:0]               data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/sld_parser.sv
`timescale 1ns / 1ps
// Frame parser: phase register, counters, checksum and config registers.
// Depends on sld_pkg.
module sld_parser import sld_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      op,
   input  logic [7:0]                rx_byte,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]               csr_data,
   output logic                      res_valid,
   output rsp_type                   res,
   output parser_status_type         status
);

   logic [15:0]            timeout_ff, plane_ff;
   logic [3:0]             phase_ff, phase_in;
   logic [7:0]             command_ff, command_in;
   logic [7:0]             len_high_ff, len_high_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [15:0]            count_ff, count_in;
   logic [7:0]             sum_ff, sum_in;
   logic [15:0]            idle_ff, idle_in;

   logic [15:0] limit, idle_inc, length_ext, count_inc;
   logic [15:0] assembled;

   assign limit      = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign idle_inc   = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
   assign length_ext = 16'(length_ff);
   assign count_inc  = count_ff + 16'd1;
   assign assembled  = {len_high_ff, rx_byte};

   assign status.phase = phase_ff;

   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      len_high_in = len_high_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      idle_in     = idle_ff;
      res_valid   = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.command      = command_ff;
      res.target       = TGT_NONE;
      res.payload_byte = 8'd0;
      res.byte_index   = count_ff;
      res.plane        = 1'b0;
      res.frame_length = length_ext;

      if (op == OP_TICK) begin
         if (phase_ff == PH_HUNT1 || phase_ff > PH_SUM) begin
            phase_in = PH_HUNT1;
            idle_in  = 16'd0;
         end else if (idle_inc >= limit) begin
            res_valid = 1'b1;
            res.kind  = KIND_TIMEOUT;
            phase_in  = PH_HUNT1;
            idle_in   = 16'd0;
         end else begin
            idle_in = idle_inc;
         end
      end else begin
         idle_in = 16'd0;
         case (phase_ff)
            PH_HUNT2: phase_in = (rx_byte == SYNC_B) ? PH_HUNT3 : PH_HUNT1;
            PH_HUNT3: phase_in = (rx_byte == SYNC_C) ? PH_CMD : PH_HUNT1;
            PH_CMD: begin
               command_in = rx_byte;
               phase_in   = PH_LENH;
            end
            PH_LENH: begin
               len_high_in = rx_byte;
               phase_in    = PH_LENL;
            end
            PH_LENL: begin
               length_in = assembled[LENGTH_BITS-1:0];
               count_in  = 16'd0;
               sum_in    = 8'd0;
               phase_in  = (assembled[LENGTH_BITS-1:0] == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               res_valid        = 1'b1;
               res.payload_byte = rx_byte;
               // screen frames split into two planes
               if (command_ff == CMD_SCREEN && count_ff >= plane_ff) begin
                  res.byte_index = count_ff - plane_ff;
                  res.plane      = 1'b1;
               end
               sum_in   = sum_ff + rx_byte;
               count_in = count_inc;
               if (count_inc >= length_ext) phase_in = PH_SUM;
            end
            PH_SUM: begin
               res_valid = 1'b1;
               if (rx_byte == sum_ff) begin
                  res.kind = KIND_GOOD;
                  if (command_ff == CMD_SCREEN)    res.target = TGT_SCREEN;
                  else if (command_ff == CMD_CALC) res.target = TGT_CALC;
               end else begin
                  res.kind = KIND_BAD_SUM;
               end
               phase_in = PH_HUNT1;
            end
            default: phase_in = (rx_byte == SYNC_A) ? PH_HUNT2 : PH_HUNT1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT1;
         command_ff  <= 8'd0;
         len_high_ff <= 8'd0;
         length_ff   <= '0;
         count_ff    <= 16'd0;
         sum_ff      <= 8'd0;
         idle_ff     <= 16'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         len_high_ff <= len_high_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         idle_ff     <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         plane_ff   <= PLANE_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_TIMEOUT)    timeout_ff <= csr_data;
         else if (csr_index == CSR_PLANE) plane_ff   <= csr_data;
      end
   end

endmodule

// File: sv/sld_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue between the parser and the result channel.
// Depends on sld_pkg.
module sld_out_queue import sld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsp_type          push_data,
   input  logic             pop,
   output logic             out_valid,
   output rsp_type          out_data,
   output queue_status_type status
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign out_valid    = (count_ff != 2'd0);
   assign out_data     = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: sv/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps
// Sync/length/checksum deframer, top level. Depends on sld_pkg, sld_if,
// sld_parser and sld_out_queue.
// Each result is written into the result queue and presented on rsp_ch from there.
// Throughput: one request beat per cycle; req_ch.ready drops only while the
// two-entry result queue is full, so the queue depth sets the stall point.
// Reset (synchronous): hunting, counters and queue cleared, registers 250/2888.
module sync_length_checksum_deframer import sld_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sld_req_if.sink       req_ch,
   sld_rsp_if.source     rsp_ch,
   sld_csr_if.sink       csr_ch
);

   logic              accept;
   logic              res_valid;
   rsp_type           res;
   rsp_type           q_data;
   logic              q_valid;
   parser_status_type p_status;
   queue_status_type  q_status;

   // A beat is taken whenever the queue has a free slot; each beat makes at
   // most one result, so a push never overflows.
   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;

   sld_parser #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_ch.op),
      .rx_byte   (req_ch.rx_byte),
      .csr_write (csr_ch.valid && csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .res_valid (res_valid),
      .res       (res),
      .status    (p_status)
   );

   sld_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .pop       (rsp_ch.valid && rsp_ch.ready),
      .out_valid (q_valid),
      .out_data  (q_data),
      .status    (q_status)
   );

   assign rsp_ch.valid        = q_valid;
   assign rsp_ch.kind         = q_data.kind;
   assign rsp_ch.command      = q_data.command;
   assign rsp_ch.target       = q_data.target;
   assign rsp_ch.payload_byte = q_data.payload_byte;
   assign rsp_ch.byte_index   = q_data.byte_index;
   assign rsp_ch.plane        = q_data.plane;
   assign rsp_ch.frame_length = q_data.frame_length;

   // queue never holds more than two beats
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("result queue count out of range");

   // rsp_ch is valid in the cycle after any push
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid |=> rsp_ch.valid)
      else $error("pushed result not visible");

   // ticks while hunting produce nothing
   a_hunt_tick: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == OP_TICK && p_status.phase == PH_HUNT1 |-> !res_valid)
      else $error("tick while hunting made a result");

   // every payload-phase byte is emitted as a payload beat
   a_data_emit: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == OP_BYTE && p_status.phase == PH_DATA
      |-> res_valid && res.kind == KIND_PAYLOAD)
      else $error("payload byte not emitted");

endmodule

// File: tb/sv/sync_length_checksum_deframer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sync_length_checksum_deframer: a queued request driver,
// a result monitor with random stalls and a beat-level frame predictor.
// Depends on sld_pkg, sld_if and the deframer RTL.
module sync_length_checksum_deframer_test;
   import sld_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = 4;       // quiet margin before register writes and before the run ends
   localparam int LIMIT_CYCLES = 600000;
   localparam int PHASE_ITEMS  = 160;     // minimum request beats per register setting

   // One pending beat: a request, or a register write that waits for the block to go idle.
   typedef struct packed {
      logic                      is_cfg;
      logic                      op;
      logic [7:0]                rx_byte;
      logic [CSR_INDEX_BITS-1:0] csr_index;
      logic [15:0]               csr_data;
   } stim_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sld_req_if req_if ();
   sld_rsp_if rsp_if ();
   sld_csr_if csr_if ();

   sync_length_checksum_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #(HALF_PERIOD) clock = ~clock;

   stim_beat_type stim_q[$];
   rsp_type       expected_results[$];
   int            fail_count = 0;
   int            cycle_count = 0;

   // ---------------------------------------------------------------------------
   // Frame predictor: its own copy of the registers and parser state.
   // ---------------------------------------------------------------------------
   logic [15:0] cfg_timeout = TIMEOUT_RESET;
   logic [15:0] cfg_plane   = PLANE_RESET;

   logic [3:0]  prs_phase   = PH_HUNT1;
   logic [7:0]  prs_command = 8'd0;
   logic [7:0]  prs_len_hi  = 8'd0;
   logic [15:0] prs_length  = 16'd0;
   logic [15:0] prs_count   = 16'd0;
   logic [7:0]  prs_sum     = 8'd0;
   logic [15:0] prs_idle    = 16'd0;

   // Every result carries the command and declared length of the current frame.
   task automatic push_result(input logic [1:0] kind, input logic [1:0] target,
                              input logic [7:0] pbyte, input logic [15:0] index,
                              input logic plane);
      rsp_type r;
      r.kind         = kind;
      r.command      = prs_command;
      r.target       = target;
      r.payload_byte = pbyte;
      r.byte_index   = index;
      r.plane        = plane;
      r.frame_length = prs_length;
      expected_results.push_back(r);
   endtask

   task automatic deframe_step(input logic op, input logic [7:0] b);
      logic [15:0] limit;
      logic [15:0] index;
      logic        plane;
      logic [1:0]  target;
      if (prs_phase > PH_SUM)
         prs_phase = PH_HUNT1;
      if (op == OP_TICK) begin
         limit = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
         if (prs_phase == PH_HUNT1) begin
            // idle line between frames: tick has no effect
            prs_idle = 16'd0;
         end else begin
            if (prs_idle != 16'hFFFF)
               prs_idle = prs_idle + 16'd1;
            if (prs_idle >= limit) begin
               push_result(KIND_TIMEOUT, TGT_NONE, 8'd0, prs_count, 1'b0);
               prs_phase = PH_HUNT1;
               prs_idle  = 16'd0;
            end
         end
      end else begin
         prs_idle = 16'd0;
         case (prs_phase)
            PH_HUNT1: begin
               if (b == SYNC_A)
                  prs_phase = PH_HUNT2;
            end
            PH_HUNT2: prs_phase = (b == SYNC_B) ? PH_HUNT3 : PH_HUNT1;
            PH_HUNT3: prs_phase = (b == SYNC_C) ? PH_CMD : PH_HUNT1;
            PH_CMD: begin
               prs_command = b;
               prs_phase   = PH_LENH;
            end
            PH_LENH: begin
               prs_len_hi = b;
               prs_phase  = PH_LENL;
            end
            PH_LENL: begin
               prs_length = {prs_len_hi, b};
               prs_count  = 16'd0;
               prs_sum    = 8'd0;
               // zero length skips straight to the checksum byte
               prs_phase  = (prs_length == 16'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               index = prs_count;
               plane = 1'b0;
               // screen payload: everything past the first plane lands in plane 1
               if (prs_command == CMD_SCREEN && prs_count >= cfg_plane) begin
                  index = prs_count - cfg_plane;
                  plane = 1'b1;
               end
               push_result(KIND_PAYLOAD, TGT_NONE, b, index, plane);
               prs_sum   = prs_sum + b;
               prs_count = prs_count + 16'd1;
               if (prs_count >= prs_length)
                  prs_phase = PH_SUM;
            end
            default: begin
               if (b == prs_sum) begin
                  target = TGT_NONE;
                  if (prs_command == CMD_SCREEN)
                     target = TGT_SCREEN;
                  else if (prs_command == CMD_CALC)
                     target = TGT_CALC;
                  push_result(KIND_GOOD, target, 8'd0, prs_count, 1'b0);
               end else begin
                  push_result(KIND_BAD_SUM, TGT_NONE, 8'd0, prs_count, 1'b0);
               end
               prs_phase = PH_HUNT1;
            end
         endcase
      end
   endtask

   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [15:0] data);
      if (index == CSR_TIMEOUT)
         cfg_timeout = data;
      else if (index == CSR_PLANE)
         cfg_plane = data;
   endtask

   // Wait draw shared by both sides; burst mode gives stretches with no idling.
   function automatic int unsigned draw_wait(inout bit burst);
      if ($urandom_range(0, 49) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 5);
   endfunction

   // ---------------------------------------------------------------------------
   // Request and register driver
   // ---------------------------------------------------------------------------
   int unsigned req_gap = 0;
   int unsigned quiet_cycles = 0;    // cycles since the last accepted request beat
   bit          req_burst = 1'b0;

   always @(posedge clock) begin : request_driver
      logic          req_fire;
      logic          csr_fire;
      stim_beat_type beat;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.op      <= OP_BYTE;
         req_if.rx_byte <= 8'd0;
         csr_if.valid   <= 1'b0;
         csr_if.index   <= CSR_TIMEOUT;
         csr_if.data    <= 16'd0;
         req_gap        <= 0;
         quiet_cycles   <= 0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         csr_fire = csr_if.valid && csr_if.ready;
         if (req_fire)
            deframe_step(req_if.op, req_if.rx_byte);
         if (csr_fire)
            apply_register(csr_if.index, csr_if.data);
         quiet_cycles <= req_fire ? 0 : (quiet_cycles > 1000 ? quiet_cycles
                                                             : quiet_cycles + 1);

         if (csr_if.valid) begin
            // register write in flight; requests stay parked
            if (csr_fire)
               csr_if.valid <= 1'b0;
         end else if (req_if.valid && !req_fire) begin
            // hold the beat until the block takes it
         end else if (req_gap != 0) begin
            req_gap      <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (stim_q.size() != 0 && !stim_q[0].is_cfg) begin
            // back-to-back beats keep valid high and just swap the payload
            beat = stim_q.pop_front();
            req_if.valid   <= 1'b1;
            req_if.op      <= beat.op;
            req_if.rx_byte <= beat.rx_byte;
            req_gap        <= draw_wait(req_burst);
         end else if (stim_q.size() != 0 && !req_if.valid &&
                      quiet_cycles >= DRAIN_CYCLES && expected_results.size() == 0) begin
            // registers change only once the block has gone quiet
            beat = stim_q.pop_front();
            csr_if.valid <= 1'b1;
            csr_if.index <= beat.csr_index;
            csr_if.data  <= beat.csr_data;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor
   // ---------------------------------------------------------------------------
   int unsigned rsp_stall = 0;
   bit          rsp_burst = 1'b0;

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_monitor
      rsp_type     want;
      int unsigned stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual kind %0d index %0h",
                        $time, rsp_if.kind, rsp_if.byte_index);
            end else begin
               want = expected_results.pop_front();
               check_field("kind",         want.kind,         rsp_if.kind);
               check_field("command",      want.command,      rsp_if.command);
               check_field("target",       want.target,       rsp_if.target);
               check_field("payload_byte", want.payload_byte, rsp_if.payload_byte);
               check_field("byte_index",   want.byte_index,   rsp_if.byte_index);
               check_field("plane",        want.plane,        rsp_if.plane);
               check_field("frame_length", want.frame_length, rsp_if.frame_length);
            end
            stall = draw_wait(rsp_burst);
            rsp_stall    <= stall;
            rsp_if.ready <= (stall == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_if.ready <= (rsp_stall == 1);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus builder: fills stim_q up front, tracking the settings it will write.
   // ---------------------------------------------------------------------------
   int          gen_items = 0;
   logic [15:0] gen_timeout = TIMEOUT_RESET;
   logic [15:0] gen_plane   = PLANE_RESET;

   function automatic int unsigned gen_limit();
      return (gen_timeout == 16'd0) ? 1 : gen_timeout;
   endfunction

   task automatic add_req(input logic op, input logic [7:0] b);
      stim_beat_type beat;
      beat           = '0;
      beat.op        = op;
      beat.rx_byte   = b;
      stim_q.push_back(beat);
      gen_items++;
   endtask

   task automatic add_setting(input logic [15:0] timeout, input logic [15:0] plane);
      stim_beat_type beat;
      beat           = '0;
      beat.is_cfg    = 1'b1;
      beat.csr_index = CSR_TIMEOUT;
      beat.csr_data  = timeout;
      stim_q.push_back(beat);
      beat.csr_index = CSR_PLANE;
      beat.csr_data  = plane;
      stim_q.push_back(beat);
      gen_timeout = timeout;
      gen_plane   = plane;
   endtask

   // A few ticks that stay under the abort threshold, now and then.
   task automatic add_idle_ticks();
      int unsigned n;
      if (gen_limit() >= 2 && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, (gen_limit() - 1) > 3 ? 3 : gen_limit() - 1);
         repeat (n) add_req(OP_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit good, input bit with_ticks);
      logic [7:0] sum;
      logic [7:0] b;
      sum = 8'd0;
      add_req(OP_BYTE, SYNC_A);
      add_req(OP_BYTE, SYNC_B);
      add_req(OP_BYTE, SYNC_C);
      add_req(OP_BYTE, cmd);
      if (with_ticks) add_idle_ticks();
      add_req(OP_BYTE, len[15:8]);
      add_req(OP_BYTE, len[7:0]);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         add_req(OP_BYTE, b);
         if (with_ticks) add_idle_ticks();
      end
      add_req(OP_BYTE, good ? sum : sum ^ 8'($urandom_range(1, 255)));
   endtask

   // Frame cut short somewhere after the first sync byte, then left idle.
   // Long tick runs only for moderate thresholds, so the item count stays bounded.
   task automatic add_cut_frame();
      logic [7:0]  head [6];
      logic [15:0] len;
      int unsigned cut;
      len  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(1, 20));
      head = '{SYNC_A, SYNC_B, SYNC_C, 8'($urandom_range(0, 3)), len[15:8], len[7:0]};
      cut  = $urandom_range(1, 9);
      for (int i = 0; i < cut; i++)
         add_req(OP_BYTE, (i < 6) ? head[i] : 8'($urandom_range(0, 255)));
      if (gen_limit() <= 16 || (gen_limit() <= 256 && $urandom_range(0, 3) == 0))
         repeat (gen_limit()) add_req(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 3))
         0, 3:    return CMD_SCREEN;
         1:       return CMD_CALC;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick_length(input logic [7:0] cmd);
      if (cmd == CMD_SCREEN && gen_plane <= 16'd8 && $urandom_range(0, 1) == 0)
         return 16'($urandom_range(0, 3 * gen_plane + 2));
      if ($urandom_range(0, 9) == 0)
         return 16'($urandom_range(13, 48));
      return 16'($urandom_range(0, 12));
   endfunction

   task automatic add_random_phase();
      int          stop_at;
      int unsigned pick;
      logic [7:0]  cmd;
      stop_at = gen_items + PHASE_ITEMS;
      while (gen_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            cmd = pick_command();
            add_frame(cmd, pick_length(cmd), $urandom_range(0, 3) != 0, 1'b1);
         end else if (pick < 80) begin
            add_cut_frame();
         end else if (pick < 90) begin
            // broken sync: wrong second or third byte
            add_req(OP_BYTE, SYNC_A);
            if ($urandom_range(0, 1) == 0)
               add_req(OP_BYTE, SYNC_B);
            add_req(OP_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : stimulus
      logic [15:0] phase_timeout [7];
      logic [15:0] phase_plane   [7];
      req_if.valid   = 1'b0;
      req_if.op      = OP_BYTE;
      req_if.rx_byte = 8'd0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_TIMEOUT;
      csr_if.data    = 16'd0;
      rsp_if.ready   = 1'b0;

      // Directed part at the reset register values.
      add_req(OP_TICK, 8'hFF);                                   // tick while hunting
      add_req(OP_BYTE, SYNC_A); add_req(OP_BYTE, 8'h00);         // bad second sync byte
      add_req(OP_BYTE, SYNC_A); add_req(OP_BYTE, SYNC_B);
      add_req(OP_BYTE, 8'hFF);                                   // bad third sync byte
      add_frame(8'hFF, 16'd0, 1'b0, 1'b0);                       // zero length, bad checksum
      add_frame(CMD_SCREEN, 16'd2, 1'b1, 1'b0);
      add_frame(CMD_CALC, 16'd1, 1'b1, 1'b0);
      add_req(OP_BYTE, SYNC_A); add_req(OP_TICK, 8'h00);         // tick inside a frame
      add_req(OP_BYTE, SYNC_B);

      // Register settings: extremes, zero values and the reset pair.
      phase_timeout = '{16'd1, 16'd3, 16'hFFFF, 16'd5, 16'd0, 16'd2, TIMEOUT_RESET};
      phase_plane   = '{16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd2, 16'd7, PLANE_RESET};
      for (int p = 0; p < 7; p++) begin
         add_setting(phase_timeout[p], phase_plane[p]);
         add_random_phase();
      end
      repeat (2) begin
         add_setting(16'($urandom_range(1, 12)), 16'($urandom_range(1, 20)));
         add_random_phase();
      end

      @(posedge clock);
      @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_if.valid || csr_if.valid ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
